[src/ptie_pkg.sv]
package ptie_pkg;

    // Field widths
    localparam int VAL_W  = 17;
    localparam int CODE_W = 10;
    localparam int TYPE_W = 2;

    // Event types
    localparam logic [TYPE_W-1:0] EV_SYNC = 2'd0;
    localparam logic [TYPE_W-1:0] EV_KEY  = 2'd1;
    localparam logic [TYPE_W-1:0] EV_REL  = 2'd2;
    localparam logic [TYPE_W-1:0] EV_ABS  = 2'd3;

    // Event codes
    localparam logic [CODE_W-1:0] CODE_SYN        = 10'd0;
    localparam logic [CODE_W-1:0] CODE_X          = 10'd0;
    localparam logic [CODE_W-1:0] CODE_Y          = 10'd1;
    localparam logic [CODE_W-1:0] CODE_WHEEL      = 10'd8;
    localparam logic [CODE_W-1:0] CODE_BTN_LEFT   = 10'd272;
    localparam logic [CODE_W-1:0] CODE_BTN_RIGHT  = 10'd273;
    localparam logic [CODE_W-1:0] CODE_BTN_MIDDLE = 10'd274;
    localparam logic [CODE_W-1:0] CODE_BTN_TOUCH  = 10'd330;
    localparam logic [CODE_W-1:0] CODE_BACK       = 10'd158;
    localparam logic [CODE_W-1:0] CODE_END        = 10'd107;

    localparam logic [VAL_W-1:0] VAL_ZERO  = 17'h00000;
    localparam logic [VAL_W-1:0] VAL_ONE   = 17'h00001;
    localparam logic [VAL_W-1:0] VAL_MINUS = 17'h1FFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd2;

    // Event slots of one report, in emission order
    localparam int NUM_SLOTS = 19;
    localparam int SLOT_W    = 5;
    localparam logic [SLOT_W-1:0] SL_POS_X  = 5'd0;
    localparam logic [SLOT_W-1:0] SL_POS_Y  = 5'd1;
    localparam logic [SLOT_W-1:0] SL_POS_S  = 5'd2;
    localparam logic [SLOT_W-1:0] SL_L_AX   = 5'd3;
    localparam logic [SLOT_W-1:0] SL_L_AY   = 5'd4;
    localparam logic [SLOT_W-1:0] SL_L_KEY  = 5'd5;
    localparam logic [SLOT_W-1:0] SL_L_S    = 5'd6;
    localparam logic [SLOT_W-1:0] SL_R_AX   = 5'd7;
    localparam logic [SLOT_W-1:0] SL_R_AY   = 5'd8;
    localparam logic [SLOT_W-1:0] SL_R_KEY  = 5'd9;
    localparam logic [SLOT_W-1:0] SL_R_S    = 5'd10;
    localparam logic [SLOT_W-1:0] SL_M_AX   = 5'd11;
    localparam logic [SLOT_W-1:0] SL_M_AY   = 5'd12;
    localparam logic [SLOT_W-1:0] SL_M_KEY  = 5'd13;
    localparam logic [SLOT_W-1:0] SL_M_S    = 5'd14;
    localparam logic [SLOT_W-1:0] SL_WU     = 5'd15;
    localparam logic [SLOT_W-1:0] SL_WU_S   = 5'd16;
    localparam logic [SLOT_W-1:0] SL_WD     = 5'd17;
    localparam logic [SLOT_W-1:0] SL_WD_S   = 5'd18;

    // One classified report, as handed from front to back
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic                 touch;
        logic                 rel;
        logic                 left_down;
        logic                 right_down;
        logic                 middle_down;
        logic [VAL_W-1:0]     px;
        logic [VAL_W-1:0]     py;
        logic [VAL_W-1:0]     ax;
        logic [VAL_W-1:0]     ay;
    } job_t;

endpackage

[src/ptie_front.sv]
module ptie_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [ptie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [4:0]                         button_mask,
    input  logic [15:0]                        x_pos,
    input  logic [15:0]                        y_pos,
    input  logic                               q_full,
    output logic                               q_push,
    output ptie_pkg::job_t                     q_job
);

    logic touch_reg, rel_reg, enable_reg;
    logic [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic left_held_reg, right_held_reg, middle_held_reg;

    logic                  accept;
    logic [32:0]           x_ext, y_ext;
    logic [COORD_BITS-1:0] xm, ym;
    logic [33:0]           dx_full, dy_full, ax_full, ay_full;
    logic                  l_dn, r_dn, m_dn;
    logic                  l_edge, r_edge, m_edge;
    logic                  l_drag, r_drag, m_drag;
    logic [ptie_pkg::NUM_SLOTS-1:0] slots;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Coordinates masked to COORD_BITS, values wrapped to 17 bits
    assign x_ext   = 33'(x_pos);
    assign y_ext   = 33'(y_pos);
    assign xm      = x_ext[COORD_BITS-1:0];
    assign ym      = y_ext[COORD_BITS-1:0];
    assign ax_full = 34'(xm);
    assign ay_full = 34'(ym);
    assign dx_full = 34'(xm) - 34'(last_x_reg);
    assign dy_full = 34'(ym) - 34'(last_y_reg);

    // Button classification
    assign l_dn   = button_mask[0];
    assign m_dn   = button_mask[1];
    assign r_dn   = button_mask[2];
    assign l_edge = l_dn != left_held_reg;
    assign r_edge = r_dn != right_held_reg;
    assign m_edge = m_dn != middle_held_reg;
    assign l_drag = !l_edge && left_held_reg && !rel_reg;
    assign r_drag = !r_edge && right_held_reg && !rel_reg;
    assign m_drag = !m_edge && middle_held_reg && !rel_reg;

    // Slot enables for this report
    always_comb
    begin
        slots = '0;
        slots[ptie_pkg::SL_POS_X] = !touch_reg;
        slots[ptie_pkg::SL_POS_Y] = !touch_reg;
        slots[ptie_pkg::SL_POS_S] = !touch_reg;
        slots[ptie_pkg::SL_L_AX]  = (l_edge && !rel_reg) || l_drag;
        slots[ptie_pkg::SL_L_AY]  = (l_edge && !rel_reg) || l_drag;
        slots[ptie_pkg::SL_L_KEY] = l_edge;
        slots[ptie_pkg::SL_L_S]   = l_edge || l_drag;
        slots[ptie_pkg::SL_R_AX]  = r_drag;
        slots[ptie_pkg::SL_R_AY]  = r_drag;
        slots[ptie_pkg::SL_R_KEY] = r_edge;
        slots[ptie_pkg::SL_R_S]   = r_edge || r_drag;
        slots[ptie_pkg::SL_M_AX]  = m_drag;
        slots[ptie_pkg::SL_M_AY]  = m_drag;
        slots[ptie_pkg::SL_M_KEY] = m_edge;
        slots[ptie_pkg::SL_M_S]   = m_edge || m_drag;
        slots[ptie_pkg::SL_WU]    = button_mask[3];
        slots[ptie_pkg::SL_WU_S]  = button_mask[3];
        slots[ptie_pkg::SL_WD]    = button_mask[4];
        slots[ptie_pkg::SL_WD_S]  = button_mask[4];
    end

    // Job record
    always_comb
    begin
        q_job.slots       = slots;
        q_job.touch       = touch_reg;
        q_job.rel         = rel_reg;
        q_job.left_down   = l_dn;
        q_job.right_down  = r_dn;
        q_job.middle_down = m_dn;
        q_job.ax          = ax_full[ptie_pkg::VAL_W-1:0];
        q_job.ay          = ay_full[ptie_pkg::VAL_W-1:0];
        q_job.px          = rel_reg ? dx_full[ptie_pkg::VAL_W-1:0]
                                    : ax_full[ptie_pkg::VAL_W-1:0];
        q_job.py          = rel_reg ? dy_full[ptie_pkg::VAL_W-1:0]
                                    : ay_full[ptie_pkg::VAL_W-1:0];
    end

    // Empty runs are dropped here
    assign q_push = accept && enable_reg && (slots != '0);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_reg  <= 1'b0;
            rel_reg    <= 1'b0;
            enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ptie_pkg::CFG_TOUCH:  touch_reg  <= cfg_data;
                ptie_pkg::CFG_REL:    rel_reg    <= cfg_data;
                ptie_pkg::CFG_ENABLE: enable_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            left_held_reg   <= 1'b0;
            right_held_reg  <= 1'b0;
            middle_held_reg <= 1'b0;
        end
        else if (accept && enable_reg)
        begin
            last_x_reg      <= xm;
            last_y_reg      <= ym;
            left_held_reg   <= l_dn;
            right_held_reg  <= r_dn;
            middle_held_reg <= m_dn;
        end
    end

endmodule

[src/ptie_queue.sv]
module ptie_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptie_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output ptie_pkg::job_t q_job
);

    localparam int DEPTH = 2;

    ptie_pkg::job_t mem [DEPTH];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_pop;

    assign full    = count_reg == 2'(DEPTH);
    assign q_valid = count_reg != 2'd0;
    assign q_job   = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

endmodule

[src/ptie_back.sv]
module ptie_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  ptie_pkg::job_t                      q_job,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptie_pkg::TYPE_W-1:0]         event_type,
    output logic [ptie_pkg::CODE_W-1:0]         event_code,
    output logic signed [ptie_pkg::VAL_W-1:0]   event_value,
    output logic                                last_event
);

    ptie_pkg::job_t                  job_reg;
    logic [ptie_pkg::NUM_SLOTS-1:0]  mask_reg, mask_next;
    logic                            out_valid_reg;
    logic [ptie_pkg::TYPE_W-1:0]     type_reg;
    logic [ptie_pkg::CODE_W-1:0]     code_reg;
    logic [ptie_pkg::VAL_W-1:0]      value_reg;
    logic                            last_reg;

    logic [ptie_pkg::NUM_SLOTS-1:0]  sel_onehot, rest, rem;
    logic [ptie_pkg::SLOT_W-1:0]     sel_idx;
    logic                            adv;
    logic [ptie_pkg::TYPE_W-1:0]     ev_type;
    logic [ptie_pkg::CODE_W-1:0]     ev_code;
    logic [ptie_pkg::VAL_W-1:0]      ev_value;

    // Lowest pending slot
    assign sel_onehot = mask_reg & (~mask_reg + 1'b1);
    assign rest       = mask_reg & ~sel_onehot;

    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < ptie_pkg::NUM_SLOTS; i++)
        begin
            if (sel_onehot[i])
            begin
                sel_idx = sel_idx | ptie_pkg::SLOT_W'(i);
            end
        end
    end

    // Slot to event
    always_comb
    begin
        ev_type  = ptie_pkg::EV_SYNC;
        ev_code  = ptie_pkg::CODE_SYN;
        ev_value = ptie_pkg::VAL_ZERO;
        unique case (sel_idx)
            ptie_pkg::SL_POS_X:
            begin
                ev_type  = job_reg.rel ? ptie_pkg::EV_REL : ptie_pkg::EV_ABS;
                ev_code  = ptie_pkg::CODE_X;
                ev_value = job_reg.px;
            end
            ptie_pkg::SL_POS_Y:
            begin
                ev_type  = job_reg.rel ? ptie_pkg::EV_REL : ptie_pkg::EV_ABS;
                ev_code  = ptie_pkg::CODE_Y;
                ev_value = job_reg.py;
            end
            ptie_pkg::SL_L_AX, ptie_pkg::SL_R_AX, ptie_pkg::SL_M_AX:
            begin
                ev_type  = ptie_pkg::EV_ABS;
                ev_code  = ptie_pkg::CODE_X;
                ev_value = job_reg.ax;
            end
            ptie_pkg::SL_L_AY, ptie_pkg::SL_R_AY, ptie_pkg::SL_M_AY:
            begin
                ev_type  = ptie_pkg::EV_ABS;
                ev_code  = ptie_pkg::CODE_Y;
                ev_value = job_reg.ay;
            end
            ptie_pkg::SL_L_KEY:
            begin
                ev_type  = ptie_pkg::EV_KEY;
                ev_code  = job_reg.touch ? ptie_pkg::CODE_BTN_TOUCH
                                         : ptie_pkg::CODE_BTN_LEFT;
                ev_value = job_reg.left_down ? ptie_pkg::VAL_ONE : ptie_pkg::VAL_ZERO;
            end
            ptie_pkg::SL_R_KEY:
            begin
                ev_type  = ptie_pkg::EV_KEY;
                ev_code  = job_reg.touch ? ptie_pkg::CODE_BACK
                                         : ptie_pkg::CODE_BTN_RIGHT;
                ev_value = job_reg.right_down ? ptie_pkg::VAL_ONE : ptie_pkg::VAL_ZERO;
            end
            ptie_pkg::SL_M_KEY:
            begin
                ev_type  = ptie_pkg::EV_KEY;
                ev_code  = job_reg.touch ? ptie_pkg::CODE_END
                                         : ptie_pkg::CODE_BTN_MIDDLE;
                ev_value = job_reg.middle_down ? ptie_pkg::VAL_ONE : ptie_pkg::VAL_ZERO;
            end
            ptie_pkg::SL_WU:
            begin
                ev_type  = ptie_pkg::EV_REL;
                ev_code  = ptie_pkg::CODE_WHEEL;
                ev_value = ptie_pkg::VAL_ONE;
            end
            ptie_pkg::SL_WD:
            begin
                ev_type  = ptie_pkg::EV_REL;
                ev_code  = ptie_pkg::CODE_WHEEL;
                ev_value = ptie_pkg::VAL_MINUS;
            end
            // sync slots and unused codes
            default: ;
        endcase
    end

    // Emit when output register is free or being drained
    assign adv       = (mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign rem       = adv ? rest : mask_reg;
    assign q_pop     = (rem == '0) && q_valid;
    assign mask_next = q_pop ? q_job.slots : rem;

    // Current job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            type_reg  <= ev_type;
            code_reg  <= ev_code;
            value_reg <= ev_value;
            last_reg  <= rest == '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_type  = type_reg;
    assign event_code  = code_reg;
    assign event_value = $signed(value_reg);
    assign last_event  = last_reg;

    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) |-> $onehot(sel_onehot))
        else $error("slot select not one-hot");

    // An event not marked last leaves work pending
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && rest != '0) |=> (mask_reg != '0))
        else $error("run ended without last event");

endmodule

[src/pointer_to_input_event_encoder.sv]
// The first event of a report passes the queue slot, the sequencer's job register and
// then the event output register before it appears on the output.
// Throughput: one event per cycle while out_stall is low; a report has 1 to 17 events,
// emitted in turn by the single event sequencer; consecutive reports follow without gaps.
// Reset clears the configuration, the position and held-button state, the two-entry queue
// and the output valid; payload registers are not reset.
module pointer_to_input_event_encoder #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ptie_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                                cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [4:0]                          button_mask,
    input  logic [15:0]                         x_pos,
    input  logic [15:0]                         y_pos,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptie_pkg::TYPE_W-1:0]         event_type,
    output logic [ptie_pkg::CODE_W-1:0]         event_code,
    output logic signed [ptie_pkg::VAL_W-1:0]   event_value,
    output logic                                last_event
);

    logic           q_full, q_push, q_pop, q_valid;
    ptie_pkg::job_t push_job, head_job;

    // Classification and pointer state
    ptie_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .button_mask (button_mask),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    // Job queue
    ptie_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (head_job)
    );

    // Event sequencer
    ptie_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .last_event  (last_event)
    );

endmodule
